@@ hdl/bhbs_pkg.sv @@
package bhbs_pkg;

   // default build
   localparam int NUM_BLOCKS_DEF  = 1024;
   localparam int BIN_SHIFT_DEF   = 4;
   localparam int WEIGHT_BITS_DEF = 16;

   // fixed field widths
   localparam int SAMPLE_W = 8;
   localparam int BLOCK_W  = 10;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // fixed point
   localparam int ALPHA_FRAC = 16;               // learn rate is Q0.16
   localparam int WEIGHT_ONE = 16384;            // 1.0 in Q2.14
   localparam int KEEP_W     = ALPHA_FRAC + 1;   // 1 - alpha, up to 1.0
   localparam int GAIN_W     = ALPHA_FRAC - 1;   // alpha in Q1.14 after rounding
   localparam int GAIN_SHIFT = 2;

   // register reset values
   localparam logic [CSR_W-1:0] LEARN_RATE_RST       = 16'd3277;
   localparam logic [CSR_W-1:0] LUMA_THRESHOLD_RST   = 16'd4096;
   localparam logic [CSR_W-1:0] CHROMA_THRESHOLD_RST = 16'd8192;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARN_RATE       = 2'd0,
      CSR_LUMA_THRESHOLD   = 2'd1,
      CSR_CHROMA_THRESHOLD = 2'd2,
      CSR_UNUSED           = 2'd3
   } csr_index_type;

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_INIT   = 7'b0000100,
      ST_UPDATE = 7'b0001000,
      ST_SWEEP  = 7'b0010000,
      ST_DRAIN  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

endpackage

@@ hdl/bhbs_ram.sv @@
module bhbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/bhbs_decay.sv @@
module bhbs_decay #(
   parameter int WEIGHT_BITS = bhbs_pkg::WEIGHT_BITS_DEF,
   parameter int ADDR_W      = 16,
   parameter int SLOT_W      = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bhbs_pkg::CSR_W-1:0]    learn_rate,
   // read issued this cycle
   input  logic                          in_valid,
   input  logic [ADDR_W-1:0]             in_addr,
   input  logic [SLOT_W-1:0]             in_slot,
   // RAM data, arriving the cycle after the read
   input  logic [WEIGHT_BITS-1:0]        rd_weight,
   input  logic                          rd_mark,
   output logic                          busy,
   output logic                          wr_valid,
   output logic [ADDR_W-1:0]             wr_addr,
   output logic [SLOT_W-1:0]             wr_slot,
   output logic [WEIGHT_BITS-1:0]        wr_weight
);
   import bhbs_pkg::*;

   localparam int ProdW = WEIGHT_BITS + KEEP_W;
   localparam int SumW  = ((WEIGHT_BITS > GAIN_W) ? WEIGHT_BITS : GAIN_W) + 1;
   localparam logic [WEIGHT_BITS-1:0] WeightTop = '1;
   localparam logic [ProdW-1:0] RoundHalf = ProdW'(1) << (ALPHA_FRAC - 1);

   logic [KEEP_W-1:0] keep;
   logic [GAIN_W-1:0] gain;

   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [SLOT_W-1:0] s1_slot_ff;

   logic              s2_valid_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic [SLOT_W-1:0] s2_slot_ff;
   logic              mark_ff;
   logic [ProdW-1:0]  prod_ff;
   logic [ProdW-1:0]  prod_in;

   logic [ProdW-1:0]       rounded;
   logic [WEIGHT_BITS-1:0] decayed;
   logic [SumW-1:0]        sum;

   assign keep = (KEEP_W'(1) << ALPHA_FRAC) - KEEP_W'(learn_rate);
   assign gain = GAIN_W'((KEEP_W'(learn_rate) + KEEP_W'(2)) >> GAIN_SHIFT);

   assign prod_in = ProdW'(rd_weight) * ProdW'(keep);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_addr_ff <= in_addr;
      s1_slot_ff <= in_slot;
      s2_addr_ff <= s1_addr_ff;
      s2_slot_ff <= s1_slot_ff;
      mark_ff    <= rd_mark;
      prod_ff    <= prod_in;
   end

   // round half up; the decayed weight never exceeds the old one
   always_comb begin
      rounded = prod_ff + RoundHalf;
      decayed = rounded[ALPHA_FRAC +: WEIGHT_BITS];
      sum     = SumW'(decayed) + (mark_ff ? SumW'(gain) : SumW'(0));
      if (sum > SumW'(WeightTop)) begin
         wr_weight = WeightTop;
      end else begin
         wr_weight = sum[WEIGHT_BITS-1:0];
      end
   end

   assign wr_valid = s2_valid_ff;
   assign wr_addr  = s2_addr_ff;
   assign wr_slot  = s2_slot_ff;
   assign busy     = s1_valid_ff | s2_valid_ff;

endmodule

@@ hdl/block_histogram_background_subtractor_unit.sv @@
// Block-histogram background subtractor.
// Request channel (req_*): one YCrCb pixel per request, pixels in block order,
// with its block number, a mode bit (0 seeds the model, 1 classifies and
// learns) and block_end on the last pixel of a block.
// Response channel (rsp_*): one foreground bit per update-mode request,
// nothing for initialize-mode requests.
// csr_*: learn rate, luma and chroma thresholds; write only while idle.
// All bin weights live in one RAM (3 channels x bins for each block), the hit
// marks of the block in progress in a second one. Each request is handled
// by a sequencer that reads or writes one weight per cycle on that RAM:
//   initialize writes one seed weight per channel; update reads three and
//   responds, with block_end only after a sweep of all bins of the block,
//   one bin per cycle through a two-stage decay pipeline, and its drain.
// A new request is taken as soon as the sequencer is back in idle, even if
// the previous response is still held; a stalled response keeps the
// sequencer in its last state until the response register frees up.
// After reset the block clears both RAMs, one entry per cycle, through all
// NUM_BLOCKS * 3 * (256 >> BIN_SHIFT) weight entries (49152 at default)
// before req_ready first rises. Configuration writes are taken meanwhile.
module block_histogram_background_subtractor_unit #(
   parameter int NUM_BLOCKS  = bhbs_pkg::NUM_BLOCKS_DEF,
   parameter int BIN_SHIFT   = bhbs_pkg::BIN_SHIFT_DEF,
   parameter int WEIGHT_BITS = bhbs_pkg::WEIGHT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [bhbs_pkg::BLOCK_W-1:0]      req_block_number,
   input  logic [bhbs_pkg::SAMPLE_W-1:0]     req_luma,
   input  logic [bhbs_pkg::SAMPLE_W-1:0]     req_red_diff,
   input  logic [bhbs_pkg::SAMPLE_W-1:0]     req_blue_diff,
   input  logic                              req_block_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_foreground,
   input  logic                              csr_write_enable,
   input  logic [bhbs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bhbs_pkg::CSR_W-1:0]        csr_write_data
);
   import bhbs_pkg::*;

   localparam int Nbins = 256 >> BIN_SHIFT;
   localparam int Rows  = 3 * Nbins;
   localparam int Depth = NUM_BLOCKS * Rows;
   localparam int AddrW = $clog2(Depth);
   localparam int SlotW = $clog2(Rows);
   localparam int BinW  = SAMPLE_W - BIN_SHIFT;
   localparam int CmpW  = (WEIGHT_BITS > CSR_W) ? WEIGHT_BITS : CSR_W;
   localparam logic [31:0] NumBlocksL = 32'(NUM_BLOCKS);
   localparam logic [WEIGHT_BITS-1:0] InitWeight =
      (WEIGHT_BITS > 14) ? WEIGHT_BITS'(WEIGHT_ONE) : '1;

   state_type state_ff, state_in;

   logic [CSR_W-1:0] learn_rate_ff;
   logic [CSR_W-1:0] luma_thr_ff;
   logic [CSR_W-1:0] chroma_thr_ff;

   logic [AddrW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [1:0]       ch_cnt_ff, ch_cnt_in;
   logic [SlotW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic             fg_ff, fg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_fg_ff, rsp_fg_in;

   logic [AddrW-1:0] base_ff, base_in;
   logic [SlotW-1:0] slot_ff [3];
   logic [SlotW-1:0] slot_in [3];
   logic             blk_end_ff, blk_end_in;

   logic             accept;
   logic             in_range;
   logic [SlotW-1:0] cur_slot;
   logic [CSR_W-1:0] cur_thr;
   logic             below;

   logic                   wt_wr_en, wt_rd_en;
   logic [AddrW-1:0]       wt_wr_addr, wt_rd_addr;
   logic [WEIGHT_BITS-1:0] wt_wr_data, wt_rd_data;
   logic                   mk_wr_en, mk_rd_en;
   logic [SlotW-1:0]       mk_wr_addr, mk_rd_addr;
   logic [0:0]             mk_wr_data, mk_rd_data;

   logic                   dec_in_valid;
   logic                   dec_busy;
   logic                   dec_wr_valid;
   logic [AddrW-1:0]       dec_wr_addr;
   logic [SlotW-1:0]       dec_wr_slot;
   logic [WEIGHT_BITS-1:0] dec_wr_weight;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff <= LEARN_RATE_RST;
         luma_thr_ff   <= LUMA_THRESHOLD_RST;
         chroma_thr_ff <= CHROMA_THRESHOLD_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEARN_RATE:       learn_rate_ff <= csr_write_data;
            CSR_LUMA_THRESHOLD:   luma_thr_ff   <= csr_write_data;
            CSR_CHROMA_THRESHOLD: chroma_thr_ff <= csr_write_data;
            CSR_UNUSED:           ;
            default:              ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign in_range  = (32'(req_block_number) < NumBlocksL);

   always_comb begin
      base_in    = AddrW'(32'(req_block_number) * 32'(Rows));
      slot_in[0] = SlotW'(0 * Nbins) + SlotW'(BinW'(req_luma >> BIN_SHIFT));
      slot_in[1] = SlotW'(1 * Nbins) + SlotW'(BinW'(req_red_diff >> BIN_SHIFT));
      slot_in[2] = SlotW'(2 * Nbins) + SlotW'(BinW'(req_blue_diff >> BIN_SHIFT));
      blk_end_in = req_block_end;
   end

   always_comb begin
      unique case (ch_cnt_ff)
         2'd0:    cur_slot = slot_ff[0];
         2'd1:    cur_slot = slot_ff[1];
         default: cur_slot = slot_ff[2];
      endcase
      // weight arriving now belongs to the channel read last cycle
      cur_thr = (ch_cnt_ff == 2'd1) ? luma_thr_ff : chroma_thr_ff;
      below   = (CmpW'(wt_rd_data) < CmpW'(cur_thr));
   end

   // sequencer; a request starts only from idle, after every write of the
   // previous one has landed, so no read can overtake a pending write
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      ch_cnt_in    = ch_cnt_ff;
      sweep_cnt_in = sweep_cnt_ff;
      fg_in        = fg_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_fg_in    = rsp_fg_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AddrW'(1);
            if (clr_cnt_ff == AddrW'(Depth - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ch_cnt_in    = 2'd0;
            sweep_cnt_in = '0;
            fg_in        = ~in_range;
            if (accept) begin
               if (!in_range) begin
                  state_in = req_mode ? ST_DONE : ST_IDLE;
               end else begin
                  state_in = req_mode ? ST_UPDATE : ST_INIT;
               end
            end
         end
         ST_INIT: begin
            ch_cnt_in = ch_cnt_ff + 2'd1;
            if (ch_cnt_ff == 2'd2) begin
               state_in = ST_IDLE;
            end
         end
         ST_UPDATE: begin
            ch_cnt_in = ch_cnt_ff + 2'd1;
            if (ch_cnt_ff != 2'd0) begin
               fg_in = fg_ff | below;
            end
            if (ch_cnt_ff == 2'd3) begin
               state_in = blk_end_ff ? ST_SWEEP : ST_DONE;
            end
         end
         ST_SWEEP: begin
            sweep_cnt_in = sweep_cnt_ff + SlotW'(1);
            if (sweep_cnt_ff == SlotW'(Rows - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!dec_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_fg_in    = fg_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         ch_cnt_ff    <= 2'd0;
         sweep_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         ch_cnt_ff    <= ch_cnt_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fg_ff     <= fg_in;
      rsp_fg_ff <= rsp_fg_in;
      if (accept) begin
         base_ff    <= base_in;
         slot_ff    <= slot_in;
         blk_end_ff <= blk_end_in;
      end
   end

   // RAM ports
   always_comb begin
      wt_wr_en     = 1'b0;
      wt_wr_addr   = dec_wr_addr;
      wt_wr_data   = dec_wr_weight;
      wt_rd_en     = 1'b0;
      wt_rd_addr   = base_ff + AddrW'(cur_slot);
      mk_wr_en     = 1'b0;
      mk_wr_addr   = dec_wr_slot;
      mk_wr_data   = 1'b0;
      mk_rd_en     = 1'b0;
      mk_rd_addr   = sweep_cnt_ff;
      dec_in_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wt_wr_en   = 1'b1;
            wt_wr_addr = clr_cnt_ff;
            wt_wr_data = '0;
            mk_wr_en   = ({1'b0, clr_cnt_ff} < (AddrW + 1)'(Rows));
            mk_wr_addr = clr_cnt_ff[SlotW-1:0];
         end
         ST_INIT: begin
            wt_wr_en   = 1'b1;
            wt_wr_addr = base_ff + AddrW'(cur_slot);
            wt_wr_data = InitWeight;
         end
         ST_UPDATE: begin
            if (ch_cnt_ff != 2'd3) begin
               wt_rd_en   = 1'b1;
               mk_wr_en   = 1'b1;
               mk_wr_addr = cur_slot;
               mk_wr_data = 1'b1;
            end
         end
         ST_SWEEP: begin
            wt_rd_en     = 1'b1;
            wt_rd_addr   = base_ff + AddrW'(sweep_cnt_ff);
            mk_rd_en     = 1'b1;
            dec_in_valid = 1'b1;
            wt_wr_en     = dec_wr_valid;
            mk_wr_en     = dec_wr_valid;
         end
         ST_DRAIN: begin
            wt_wr_en = dec_wr_valid;
            mk_wr_en = dec_wr_valid;
         end
         ST_IDLE, ST_DONE: ;
         default: ;
      endcase
   end

   bhbs_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (Depth)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (wt_wr_en),
      .wr_addr (wt_wr_addr),
      .wr_data (wt_wr_data),
      .rd_en   (wt_rd_en),
      .rd_addr (wt_rd_addr),
      .rd_data (wt_rd_data)
   );

   bhbs_ram #(
      .WIDTH (1),
      .DEPTH (Rows)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mk_wr_en),
      .wr_addr (mk_wr_addr),
      .wr_data (mk_wr_data),
      .rd_en   (mk_rd_en),
      .rd_addr (mk_rd_addr),
      .rd_data (mk_rd_data)
   );

   bhbs_decay #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .ADDR_W      (AddrW),
      .SLOT_W      (SlotW)
   ) u_decay (
      .clock      (clock),
      .reset      (reset),
      .learn_rate (learn_rate_ff),
      .in_valid   (dec_in_valid),
      .in_addr    (wt_rd_addr),
      .in_slot    (mk_rd_addr),
      .rd_weight  (wt_rd_data),
      .rd_mark    (mk_rd_data[0]),
      .busy       (dec_busy),
      .wr_valid   (dec_wr_valid),
      .wr_addr    (dec_wr_addr),
      .wr_slot    (dec_wr_slot),
      .wr_weight  (dec_wr_weight)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_foreground = rsp_fg_ff;

   // sweep write-back trails its reads, never on the entry being read
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wt_wr_en && wt_rd_en) |-> (wt_wr_addr != wt_rd_addr))
      else $error("weight RAM read and write hit the same entry");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !dec_busy)
      else $error("response pending while sweep writes are in flight");

   a_decay_only_sweep: assert property (@(posedge clock) disable iff (reset)
      dec_wr_valid |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("decay write outside the sweep");

endmodule

@@ tb/tb.sv @@
module tb;
   import bhbs_pkg::*;

   localparam int NUM_BLOCKS      = NUM_BLOCKS_DEF;
   localparam int BIN_SHIFT       = BIN_SHIFT_DEF;
   localparam int WEIGHT_BITS     = WEIGHT_BITS_DEF;
   localparam int NBINS           = 256 >> BIN_SHIFT;
   localparam int BINS_PER_BLOCK  = 3 * NBINS;
   localparam longint unsigned WEIGHT_TOP = (64'd1 << WEIGHT_BITS) - 1;
   // longest request is an update with a sweep, plus margin
   localparam int SETTLE_CYCLES   = 3 * BINS_PER_BLOCK + 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SCENE_BLOCKS    = 12;
   localparam int CYCLE_LIMIT     = 2_000_000;

   typedef enum bit {
      MODE_INIT   = 1'b0,
      MODE_UPDATE = 1'b1
   } pixel_mode_type;

   typedef struct {
      pixel_mode_type      mode;
      bit [BLOCK_W-1:0]    block_number;
      bit [SAMPLE_W-1:0]   luma;
      bit [SAMPLE_W-1:0]   red_diff;
      bit [SAMPLE_W-1:0]   blue_diff;
      bit                  block_end;
   } pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_mode = 1'b0;
   logic [BLOCK_W-1:0]   req_block_number = '0;
   logic [SAMPLE_W-1:0]  req_luma = '0;
   logic [SAMPLE_W-1:0]  req_red_diff = '0;
   logic [SAMPLE_W-1:0]  req_blue_diff = '0;
   logic                 req_block_end = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_foreground;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_write_data = '0;

   // histogram mirror
   int unsigned    bin_weight [NUM_BLOCKS * BINS_PER_BLOCK];
   bit             hit_mark [BINS_PER_BLOCK];
   bit [CSR_W-1:0] learn_rate       = LEARN_RATE_RST;
   bit [CSR_W-1:0] luma_threshold   = LUMA_THRESHOLD_RST;
   bit [CSR_W-1:0] chroma_threshold = CHROMA_THRESHOLD_RST;
   bit             expected_foreground [$];

   // scene used to build well-formed block sequences
   int scene_block [SCENE_BLOCKS];
   int scene_color [SCENE_BLOCKS][3];
   bit scene_seeded [SCENE_BLOCKS];

   int  errors = 0;
   int  sent_init = 0;
   int  sent_update = 0;
   int  sweeps = 0;
   int  csr_writes = 0;
   int  checked = 0;
   int  flagged = 0;
   bit  sender_gaps_on = 1'b1;
   bit  receiver_stalls_on = 1'b1;
   bit  hold_off_pending = 1'b0;

   block_histogram_background_subtractor_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_block_number (req_block_number),
      .req_luma         (req_luma),
      .req_red_diff     (req_red_diff),
      .req_blue_diff    (req_blue_diff),
      .req_block_end    (req_block_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_foreground   (rsp_foreground),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_weight(longint unsigned v);
      return (v > WEIGHT_TOP) ? int'(WEIGHT_TOP) : int'(v);
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_gap(bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void update_histograms(pixel_type p);
      int unsigned       base;
      int unsigned       slot;
      bit [SAMPLE_W-1:0] sample [3];
      bit [CSR_W-1:0]    limit;
      bit                fg;
      longint unsigned   w;
      longint unsigned   keep;
      longint unsigned   gain;
      sample[0] = p.luma;
      sample[1] = p.red_diff;
      sample[2] = p.blue_diff;
      fg = 1'b0;
      if (p.block_number >= NUM_BLOCKS) begin
         if (p.mode == MODE_UPDATE)
            expected_foreground.push_back(1'b1);
         return;
      end
      base = p.block_number * BINS_PER_BLOCK;
      if (p.mode == MODE_INIT) begin
         for (int c = 0; c < 3; c++)
            bin_weight[base + c * NBINS + (sample[c] >> BIN_SHIFT)] = clamp_weight(WEIGHT_ONE);
         return;
      end
      for (int c = 0; c < 3; c++) begin
         slot = c * NBINS + (sample[c] >> BIN_SHIFT);
         hit_mark[slot] = 1'b1;
         limit = (c == 0) ? luma_threshold : chroma_threshold;
         if (bin_weight[base + slot] < limit)
            fg = 1'b1;
      end
      if (p.block_end) begin
         // decay all bins of the block, reinforce the hit ones
         keep = 64'd65536 - longint'(learn_rate);
         gain = (longint'(learn_rate) + 2) >> 2;
         for (int i = 0; i < BINS_PER_BLOCK; i++) begin
            w = (longint'(bin_weight[base + i]) * keep + 32768) >> 16;
            if (hit_mark[i])
               w += gain;
            bin_weight[base + i] = clamp_weight(w);
            hit_mark[i] = 1'b0;
         end
         sweeps++;
      end
      expected_foreground.push_back(fg);
   endfunction

   function automatic pixel_type make_pixel(pixel_mode_type mode, int blk, int y, int cr,
                                            int cb, bit last);
      pixel_type p;
      p.mode = mode;
      p.block_number = BLOCK_W'(blk);
      p.luma = SAMPLE_W'(y);
      p.red_diff = SAMPLE_W'(cr);
      p.blue_diff = SAMPLE_W'(cb);
      p.block_end = last;
      return p;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_mode_type mode;
      mode = pixel_mode_type'($urandom_range(0, 1));
      return make_pixel(mode, $urandom_range(0, NUM_BLOCKS - 1), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 3) == 0);
   endfunction

   // pixel near the block's background color, sometimes an outlier
   function automatic pixel_type scene_pixel(int b, pixel_mode_type mode, bit last,
                                             bit allow_fg);
      int v [3];
      for (int c = 0; c < 3; c++) begin
         v[c] = scene_color[b][c] + int'($urandom_range(0, 16)) - 8;
         if (allow_fg && $urandom_range(0, 4) == 0)
            v[c] = $urandom_range(0, 255);
         if (v[c] < 0)
            v[c] = 0;
         if (v[c] > 255)
            v[c] = 255;
      end
      return make_pixel(mode, scene_block[b], v[0], v[1], v[2], last);
   endfunction

   task automatic send_pixel(pixel_type p);
      int gap;
      gap = idle_gap(sender_gaps_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= p.mode;
      req_block_number <= p.block_number;
      req_luma         <= p.luma;
      req_red_diff     <= p.red_diff;
      req_blue_diff    <= p.blue_diff;
      req_block_end    <= p.block_end;
      do @(posedge clock); while (req_ready !== 1'b1);
      update_histograms(p);
      if (p.mode == MODE_INIT)
         sent_init++;
      else
         sent_update++;
      if ($urandom_range(0, 99) < 3)
         sender_gaps_on = !sender_gaps_on;
   endtask

   // drop valid, drain responses, let a trailing sweep finish
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_foreground.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, bit [CSR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_LEARN_RATE:       learn_rate = value;
         CSR_LUMA_THRESHOLD:   luma_threshold = value;
         CSR_CHROMA_THRESHOLD: chroma_threshold = value;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic run_scene(int item_count);
      int stop_at;
      int b;
      int n;
      stop_at = sent_init + sent_update + item_count;
      while (sent_init + sent_update < stop_at) begin
         b = $urandom_range(0, SCENE_BLOCKS - 1);
         n = $urandom_range(1, 6);
         if (!scene_seeded[b] || $urandom_range(0, 9) == 0) begin
            for (int i = 0; i < n; i++)
               send_pixel(scene_pixel(b, MODE_INIT, $urandom_range(0, 3) == 0, 1'b0));
            scene_seeded[b] = 1'b1;
         end
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_pixel(random_pixel());
            // now and then the block is left without its block_end
            send_pixel(scene_pixel(b, MODE_UPDATE,
                                   (i == n - 1) && ($urandom_range(0, 19) != 0), 1'b1));
         end
      end
   endtask

   task automatic test_directed_cases();
      // empty model: everything is foreground
      send_pixel(make_pixel(MODE_UPDATE, 0, 0, 0, 0, 1'b0));
      send_pixel(make_pixel(MODE_INIT, 0, 0, 0, 0, 1'b0));
      // block_end in initialize mode is ignored
      send_pixel(make_pixel(MODE_INIT, 0, 255, 255, 255, 1'b1));
      send_pixel(make_pixel(MODE_UPDATE, 0, 0, 0, 0, 1'b0));
      send_pixel(make_pixel(MODE_UPDATE, 0, 255, 255, 255, 1'b0));
      send_pixel(make_pixel(MODE_UPDATE, 0, 0, 255, 0, 1'b0));
      // one unseen bin per channel
      send_pixel(make_pixel(MODE_UPDATE, 0, 8'h80, 0, 0, 1'b0));
      send_pixel(make_pixel(MODE_UPDATE, 0, 0, 8'h80, 0, 1'b0));
      send_pixel(make_pixel(MODE_UPDATE, 0, 0, 0, 8'h80, 1'b1));
      send_pixel(make_pixel(MODE_UPDATE, 0, 0, 0, 0, 1'b1));
      send_pixel(make_pixel(MODE_INIT, NUM_BLOCKS - 1, 255, 0, 255, 1'b0));
      send_pixel(make_pixel(MODE_UPDATE, NUM_BLOCKS - 1, 255, 0, 255, 1'b1));
      send_pixel(make_pixel(MODE_UPDATE, NUM_BLOCKS - 1, 255, 0, 255, 1'b1));
      // marks of block 5 land on block 6 at its block_end
      send_pixel(make_pixel(MODE_INIT, 6, 8'h40, 8'h50, 8'h60, 1'b0));
      send_pixel(make_pixel(MODE_UPDATE, 5, 8'h10, 8'h20, 8'h30, 1'b0));
      send_pixel(make_pixel(MODE_UPDATE, 6, 8'h40, 8'h50, 8'h60, 1'b1));
      send_pixel(make_pixel(MODE_UPDATE, 6, 8'h10, 8'h20, 8'h30, 1'b1));
      send_pixel(make_pixel(MODE_INIT, 10'h2AA, 8'hAA, 8'h55, 8'hAA, 1'b0));
      send_pixel(make_pixel(MODE_UPDATE, 10'h2AA, 8'hAA, 8'h55, 8'hAA, 1'b1));
      send_pixel(make_pixel(MODE_UPDATE, 10'h155, 8'h55, 8'hAA, 8'h55, 1'b1));
      wait_until_idle();
   endtask

   task automatic test_register_extremes();
      write_register(CSR_UNUSED, 16'hFFFF);
      write_register(CSR_LEARN_RATE, 16'd0);
      write_register(CSR_LUMA_THRESHOLD, 16'd0);
      write_register(CSR_CHROMA_THRESHOLD, 16'd0);
      run_scene(60);
      wait_until_idle();
      write_register(CSR_LEARN_RATE, 16'hFFFF);
      write_register(CSR_LUMA_THRESHOLD, 16'hFFFF);
      write_register(CSR_CHROMA_THRESHOLD, 16'hFFFF);
      run_scene(60);
      wait_until_idle();
      // threshold equal to 1.0 is not below it
      write_register(CSR_LEARN_RATE, 16'd1);
      write_register(CSR_LUMA_THRESHOLD, CSR_W'(WEIGHT_ONE));
      write_register(CSR_CHROMA_THRESHOLD, CSR_W'(WEIGHT_ONE + 1));
      run_scene(60);
      wait_until_idle();
      write_register(CSR_LEARN_RATE, LEARN_RATE_RST);
      write_register(CSR_LUMA_THRESHOLD, LUMA_THRESHOLD_RST);
      write_register(CSR_CHROMA_THRESHOLD, CHROMA_THRESHOLD_RST);
      write_register(CSR_UNUSED, 16'h0000);
   endtask

   task automatic test_output_backpressure();
      bit saved_gaps;
      saved_gaps = sender_gaps_on;
      hold_off_pending = 1'b1;
      sender_gaps_on = 1'b0;
      for (int i = 0; i < 40; i++)
         send_pixel(scene_pixel(i % SCENE_BLOCKS, MODE_UPDATE, (i % 8) == 7, 1'b1));
      sender_gaps_on = saved_gaps;
      wait_until_idle();
   endtask

   task automatic test_random_scenes();
      for (int phase = 0; phase < 4; phase++) begin
         case ($urandom_range(0, 3))
            0:       write_register(CSR_LEARN_RATE, 16'd0);
            1:       write_register(CSR_LEARN_RATE, 16'hFFFF);
            2:       write_register(CSR_LEARN_RATE, CSR_W'($urandom_range(0, 65535)));
            default: write_register(CSR_LEARN_RATE, CSR_W'($urandom_range(1000, 8000)));
         endcase
         write_register(CSR_LUMA_THRESHOLD,
                        ($urandom_range(0, 7) == 0) ? 16'hFFFF :
                                                      CSR_W'($urandom_range(0, 20000)));
         write_register(CSR_CHROMA_THRESHOLD,
                        ($urandom_range(0, 7) == 0) ? 16'hFFFF :
                                                      CSR_W'($urandom_range(0, 20000)));
         run_scene(360);
         wait_until_idle();
      end
   endtask

   initial begin : stimulus
      for (int b = 0; b < SCENE_BLOCKS; b++) begin
         scene_block[b] = (b == 0) ? 0 :
                          (b == 1) ? NUM_BLOCKS - 1 : $urandom_range(0, NUM_BLOCKS - 1);
         for (int c = 0; c < 3; c++)
            scene_color[b][c] = $urandom_range(0, 255);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_register_extremes();
      test_output_backpressure();
      test_random_scenes();
      $display("Sent %0d initialize and %0d update requests over %0d block sweeps, %0d csr writes.",
               sent_init, sent_update, sweeps, csr_writes);
      $display("Checked %0d responses, %0d of them foreground, %0d errors.",
               checked, flagged, errors);
      if (errors == 0) begin
         $display("block_histogram_background_subtractor_unit test passed");
      end else begin
         $display("block_histogram_background_subtractor_unit test failed");
      end
      $finish;
   end

   // response side: random stalls plus one long hold-off on request
   initial begin : response_side
      int stall_left;
      int gap;
      bit want;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_foreground.size() == 0) begin
               $error("foreground response with no request outstanding: got %0b",
                      rsp_foreground);
               errors++;
            end else begin
               want = expected_foreground.pop_front();
               if (rsp_foreground !== want) begin
                  $error("foreground mismatch: expected %0b, actual %0b", want, rsp_foreground);
                  errors++;
               end
               checked++;
               if (want)
                  flagged++;
            end
         end
         if ($urandom_range(0, 99) == 0)
            receiver_stalls_on = !receiver_stalls_on;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_left = HOLD_OFF_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            gap = idle_gap(receiver_stalls_on);
            if (gap > 0) begin
               stall_left = gap - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timed out with %0d responses outstanding.", expected_foreground.size());
      $display("block_histogram_background_subtractor_unit test failed");
      $finish;
   end

endmodule

@@ block_histogram_background_subtractor_unit.f @@
hdl/bhbs_pkg.sv
hdl/bhbs_ram.sv
hdl/bhbs_decay.sv
hdl/block_histogram_background_subtractor_unit.sv
tb/tb.sv
